>>> rtl/first_fit_heap_allocator_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int ROW_BITS     = 64;
    localparam int ROW_IDX_W    = $clog2(ROW_BITS);
    localparam int OFS_W        = $clog2(ARENA_BYTES);
    localparam int ROW_W        = OFS_W - ROW_IDX_W;
    localparam int NUM_ROWS     = ARENA_BYTES / ROW_BITS;
    localparam int SIZE_W       = 13;
    localparam int ADDR_W       = 32;

    typedef logic [OFS_W-1:0]     ofs_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [ROW_IDX_W-1:0] bit_idx_t;
    typedef logic [ROW_BITS-1:0]  bits_t;

    typedef struct packed {
        bits_t mark;
        bits_t used;
    } map_row_t;

    typedef struct packed {
        logic clear;
        logic rd_en;
        row_t rd_row;
        logic wr_en;
        row_t wr_row;
    } map_ctl_t;

    localparam logic [1:0] OP_FORMAT = 2'd0;
    localparam logic [1:0] OP_ALLOC  = 2'd1;
    localparam logic [1:0] OP_FREE   = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOFIT   = 2'd1;
    localparam logic [1:0] STAT_BADFREE = 2'd2;
    localparam logic [1:0] STAT_INVALID = 2'd3;

endpackage

>>> rtl/ffha_map.sv
module ffha_map import ffha_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  map_ctl_t ctl,
    input  map_row_t wr_data,
    output map_row_t rd_data
);

    map_row_t            mem [NUM_ROWS];
    map_row_t            rd_data_reg;
    logic [NUM_ROWS-1:0] row_valid_reg;
    logic                rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_row] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_row];
        end
    end

    // rows never written since reset or format read as all clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (ctl.clear) begin
                row_valid_reg <= '0;
            end else if (ctl.wr_en) begin
                row_valid_reg[ctl.wr_row] <= 1'b1;
            end
            if (ctl.rd_en) begin
                rd_valid_reg <= row_valid_reg[ctl.rd_row];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> rtl/first_fit_heap_allocator.sv
// First-fit heap allocator over a byte arena of up to 4096 bytes.
// Input channel s_*: one request (format, allocate or free) per handshake.
// Result channel m_*: exactly one result per request, status and payload address.
// Config channel cfg_*: writes arena_base, always ready; write only while idle.
// Block marks and in-use bits live in a 64-row x 128-bit memory (one mark and
// one in-use bit per byte offset), read through an output register.
// Allocate reads the map row by row, visiting each block or empty row in turn,
// then applies its bit updates as read-modify-write; free scans rows forward
// and backward from the block, then applies its bit updates the same way.
// One request is processed at a time; s_ready is high only when idle.
// The result sits in an output register; a stalled receiver holds it
// and the next request can still be accepted, but its result waits.
// Reset clears all row valid bits, so the arena reads as unformatted
// and empty right away; no clearing pass is needed. Format clears the
// row valid bits the same way, in the cycle the format is accepted.
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator import ffha_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_operation,
    input  logic [SIZE_W-1:0]   s_request_size,
    input  logic [ADDR_W-1:0]   s_free_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [ADDR_W-1:0]   m_payload_address,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ADDR_W-1:0]   cfg_arena_base
);

    typedef enum logic [3:0] {
        S_IDLE, S_ARD, S_AEV, S_FRD, S_FPOS, S_NRD, S_NEV,
        S_PRD, S_PEV, S_FBLD, S_URD, S_UWR, S_DONE
    } state_t;

    typedef struct packed {
        ofs_t pos;
        logic mark_en;
        logic mark_val;
        logic use_en;
        logic use_val;
    } upd_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   arena_base_reg;
    ofs_t                sentinel_reg;
    logic                formatted_reg;
    logic [SIZE_W-1:0]   size_reg;
    ofs_t                lo_reg;
    ofs_t                hi_reg;
    ofs_t                cur_reg;
    logic                cur_use_reg;
    logic                have_cur_reg;
    ofs_t                pos_reg;
    ofs_t                nxt_reg;
    logic                nxt_use_reg;
    logic                prv_ok_reg;
    logic                prv_use_reg;
    upd_t                upd_reg [3];
    logic [1:0]          upd_cnt_reg;
    logic [1:0]          upd_idx_reg;
    logic [1:0]          res_status_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic                m_valid_reg;
    logic [1:0]          m_status_reg;
    logic [ADDR_W-1:0]   m_addr_reg;

    map_ctl_t            map_ctl;
    map_row_t            map_rd;
    map_row_t            map_wr;

    bits_t               fwd_mask;
    bits_t               bwd_mask;
    bit_idx_t            fwd_bit;
    bit_idx_t            bwd_bit;
    ofs_t                fwd_pos;
    ofs_t                bwd_pos;
    ofs_t                span;
    ofs_t                payload;
    logic                fits;
    logic                split_need;
    ofs_t                split_pos;
    logic [ADDR_W-1:0]   free_ofs;
    logic                fmt_ok;
    logic                free_pos_ok;
    upd_t                upd_cur;
    bit_idx_t            pos_bit;

    ffha_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (map_ctl),
        .wr_data (map_wr),
        .rd_data (map_rd)
    );

    assign s_ready           = (state_reg == S_IDLE);
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_payload_address = m_addr_reg;

    assign upd_cur = upd_reg[upd_idx_reg];
    assign pos_bit = pos_reg[ROW_IDX_W-1:0];

    assign fmt_ok = (s_request_size >= SIZE_W'(2 * HEADER_BYTES)) &&
                    (s_request_size <= SIZE_W'(ARENA_BYTES));
    assign free_ofs    = s_free_address - arena_base_reg;
    assign free_pos_ok = (free_ofs >= ADDR_W'(HEADER_BYTES)) &&
                         ((free_ofs - ADDR_W'(HEADER_BYTES)) < ADDR_W'(sentinel_reg));

    // next mark at or after lo, previous mark at or before hi, within the row
    assign fwd_mask = map_rd.mark & ({ROW_BITS{1'b1}} << lo_reg[ROW_IDX_W-1:0]);
    assign bwd_mask = map_rd.mark &
        ({ROW_BITS{1'b1}} >> (ROW_IDX_W'(ROW_BITS - 1) - hi_reg[ROW_IDX_W-1:0]));

    always_comb begin
        fwd_bit = '0;
        bwd_bit = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (fwd_mask[i]) begin
                fwd_bit = ROW_IDX_W'(i);
            end
        end
        for (int i = 0; i < ROW_BITS; i++) begin
            if (bwd_mask[i]) begin
                bwd_bit = ROW_IDX_W'(i);
            end
        end
    end

    assign fwd_pos = {lo_reg[OFS_W-1:ROW_IDX_W], fwd_bit};
    assign bwd_pos = {hi_reg[OFS_W-1:ROW_IDX_W], bwd_bit};

    assign span       = fwd_pos - cur_reg;
    assign payload    = (span > OFS_W'(HEADER_BYTES)) ? (span - OFS_W'(HEADER_BYTES)) : '0;
    assign fits       = !cur_use_reg && ({1'b0, payload} >= size_reg);
    assign split_need = ({2'b0, payload} > ({1'b0, size_reg} + (SIZE_W+1)'(HEADER_BYTES)));
    assign split_pos  = cur_reg + OFS_W'(HEADER_BYTES) + size_reg[OFS_W-1:0];

    always_comb begin
        map_ctl.clear  = (state_reg == S_IDLE) && s_valid &&
                         (s_operation == OP_FORMAT) && fmt_ok;
        map_ctl.rd_en  = 1'b0;
        map_ctl.rd_row = lo_reg[OFS_W-1:ROW_IDX_W];
        map_ctl.wr_en  = (state_reg == S_UWR);
        map_ctl.wr_row = upd_cur.pos[OFS_W-1:ROW_IDX_W];
        case (state_reg)
            S_ARD, S_NRD: begin
                map_ctl.rd_en = 1'b1;
            end
            S_FRD: begin
                map_ctl.rd_en  = 1'b1;
                map_ctl.rd_row = pos_reg[OFS_W-1:ROW_IDX_W];
            end
            S_PRD: begin
                map_ctl.rd_en  = 1'b1;
                map_ctl.rd_row = hi_reg[OFS_W-1:ROW_IDX_W];
            end
            S_URD: begin
                map_ctl.rd_en  = 1'b1;
                map_ctl.rd_row = upd_cur.pos[OFS_W-1:ROW_IDX_W];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        map_wr = map_rd;
        if (upd_cur.mark_en) begin
            map_wr.mark[upd_cur.pos[ROW_IDX_W-1:0]] = upd_cur.mark_val;
        end
        if (upd_cur.use_en) begin
            map_wr.used[upd_cur.pos[ROW_IDX_W-1:0]] = upd_cur.use_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            arena_base_reg <= '0;
            sentinel_reg   <= '0;
            formatted_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            upd_cnt_reg    <= '0;
            upd_idx_reg    <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                arena_base_reg <= cfg_arena_base;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        size_reg       <= s_request_size;
                        res_status_reg <= STAT_INVALID;
                        res_addr_reg   <= '0;
                        upd_idx_reg    <= '0;
                        state_reg      <= S_DONE;
                        if (s_operation == OP_FORMAT) begin
                            if (fmt_ok) begin
                                sentinel_reg   <= OFS_W'(s_request_size - SIZE_W'(HEADER_BYTES));
                                formatted_reg  <= 1'b1;
                                res_status_reg <= STAT_OK;
                                upd_reg[0]     <= '{pos: '0, mark_en: 1'b1, mark_val: 1'b1,
                                                    use_en: 1'b1, use_val: 1'b0};
                                upd_reg[1]     <= '{pos: OFS_W'(s_request_size
                                                        - SIZE_W'(HEADER_BYTES)),
                                                    mark_en: 1'b1, mark_val: 1'b1,
                                                    use_en: 1'b1, use_val: 1'b0};
                                upd_cnt_reg    <= 2'd2;
                                state_reg      <= S_URD;
                            end
                        end else if (s_operation == OP_ALLOC && formatted_reg) begin
                            res_status_reg <= STAT_NOFIT;
                            lo_reg         <= '0;
                            have_cur_reg   <= 1'b0;
                            state_reg      <= S_ARD;
                        end else if (s_operation == OP_FREE && formatted_reg) begin
                            res_status_reg <= STAT_BADFREE;
                            pos_reg        <= OFS_W'(free_ofs - ADDR_W'(HEADER_BYTES));
                            if (free_pos_ok) begin
                                state_reg <= S_FRD;
                            end
                        end
                    end
                end
                S_ARD: begin
                    state_reg <= S_AEV;
                end
                S_AEV: begin
                    if (|fwd_mask) begin
                        lo_reg <= fwd_pos + 1'b1;
                        if ((fwd_pos + 1'b1) >> ROW_IDX_W != fwd_pos >> ROW_IDX_W) begin
                            state_reg <= S_ARD;
                        end
                        cur_reg      <= fwd_pos;
                        cur_use_reg  <= map_rd.used[fwd_bit];
                        have_cur_reg <= 1'b1;
                        if (have_cur_reg) begin
                            if (fits) begin
                                res_status_reg <= STAT_OK;
                                res_addr_reg   <= arena_base_reg + ADDR_W'(cur_reg)
                                                  + ADDR_W'(HEADER_BYTES);
                                upd_reg[0]     <= '{pos: cur_reg, mark_en: 1'b0,
                                                    mark_val: 1'b0, use_en: 1'b1,
                                                    use_val: 1'b1};
                                upd_reg[1]     <= '{pos: split_pos, mark_en: 1'b1,
                                                    mark_val: 1'b1, use_en: 1'b1,
                                                    use_val: 1'b0};
                                upd_cnt_reg    <= split_need ? 2'd2 : 2'd1;
                                state_reg      <= S_URD;
                            end else if (fwd_pos >= sentinel_reg) begin
                                state_reg <= S_DONE;
                            end
                        end
                    end else begin
                        lo_reg    <= {lo_reg[OFS_W-1:ROW_IDX_W] + 1'b1, {ROW_IDX_W{1'b0}}};
                        state_reg <= S_ARD;
                    end
                end
                S_FRD: begin
                    state_reg <= S_FPOS;
                end
                S_FPOS: begin
                    if (map_rd.mark[pos_bit] && map_rd.used[pos_bit]) begin
                        lo_reg    <= pos_reg + 1'b1;
                        state_reg <= S_NRD;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_NRD: begin
                    state_reg <= S_NEV;
                end
                S_NEV: begin
                    if (|fwd_mask) begin
                        nxt_reg     <= fwd_pos;
                        nxt_use_reg <= map_rd.used[fwd_bit];
                        if (pos_reg == '0) begin
                            prv_ok_reg <= 1'b0;
                            state_reg  <= S_FBLD;
                        end else begin
                            hi_reg    <= pos_reg - 1'b1;
                            state_reg <= S_PRD;
                        end
                    end else begin
                        lo_reg    <= {lo_reg[OFS_W-1:ROW_IDX_W] + 1'b1, {ROW_IDX_W{1'b0}}};
                        state_reg <= S_NRD;
                    end
                end
                S_PRD: begin
                    state_reg <= S_PEV;
                end
                S_PEV: begin
                    if (|bwd_mask) begin
                        prv_ok_reg  <= 1'b1;
                        prv_use_reg <= map_rd.used[bwd_bit];
                        state_reg   <= S_FBLD;
                    end else if (hi_reg[OFS_W-1:ROW_IDX_W] == '0) begin
                        prv_ok_reg <= 1'b0;
                        state_reg  <= S_FBLD;
                    end else begin
                        hi_reg    <= {hi_reg[OFS_W-1:ROW_IDX_W] - 1'b1, {ROW_IDX_W{1'b1}}};
                        state_reg <= S_PRD;
                    end
                end
                S_FBLD: begin
                    res_status_reg <= STAT_OK;
                    upd_reg[0]     <= '{pos: pos_reg, mark_en: prv_ok_reg && !prv_use_reg,
                                        mark_val: 1'b0, use_en: 1'b1, use_val: 1'b0};
                    upd_reg[1]     <= '{pos: nxt_reg, mark_en: 1'b1, mark_val: 1'b0,
                                        use_en: 1'b0, use_val: 1'b0};
                    upd_cnt_reg    <= ((nxt_reg < sentinel_reg) && !nxt_use_reg) ? 2'd2 : 2'd1;
                    state_reg      <= S_URD;
                end
                S_URD: begin
                    state_reg <= S_UWR;
                end
                S_UWR: begin
                    upd_idx_reg <= upd_idx_reg + 1'b1;
                    state_reg   <= (upd_idx_reg + 1'b1 == upd_cnt_reg) ? S_DONE : S_URD;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_addr_reg   <= res_addr_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `FFHA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "accepted while busy")
    `FFHA_ASSERT_NOW(a_fail_addr_zero, m_valid && (m_status != STAT_OK), m_payload_address == '0, "nonzero address on failure")
    `FFHA_ASSERT_NOW(a_upd_in_range, (state_reg == S_URD) || (state_reg == S_UWR), upd_idx_reg < upd_cnt_reg, "update index past count")

endmodule
